// File: hdl/aes_pkg.sv
// Package with AES-128 tables, types and round helper functions.
`timescale 1ns / 1ps
package aes_pkg;

  localparam int Rounds = 10;
  localparam logic [7:0] GfReduce = 8'd27;

  typedef struct packed {
    logic [127:0] state;
    logic [127:0] rkey;
    logic         encrypt;
  } cell_word_t;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [Rounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xt(input logic [7:0] b);
    xt = {b[6:0], 1'b0} ^ (b[7] ? GfReduce : 8'h00);
  endfunction

  // byte i of the state, i = 4*col + row, byte 0 in the top bits
  function automatic logic [7:0] sb(input logic [127:0] s, input int i);
    sb = s[127 - 8*i -: 8];
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) begin
      t[127 - 8*i -: 8] = inv ? INV_BOX[sb(s, i)] : FWD_BOX[sb(s, i)];
    end
    sub_bytes = t;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) t[127 - 8*((((c + r) % 4) * 4) + r) -: 8] = sb(s, c*4 + r);
        else     t[127 - 8*(c*4 + r) -: 8] = sb(s, ((c + r) % 4) * 4 + r);
      end
    end
    shift_rows = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0]   a [4];
    logic [7:0]   a2, a4, a8;
    logic [7:0]   m1 [4], m2 [4], m3 [4], m9 [4], mb [4], md [4], me [4];
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j]  = sb(s, c*4 + j);
        a2    = xt(a[j]);
        a4    = xt(a2);
        a8    = xt(a4);
        m1[j] = a[j];
        m2[j] = a2;
        m3[j] = a2 ^ a[j];
        m9[j] = a8 ^ a[j];
        mb[j] = a8 ^ a2 ^ a[j];
        md[j] = a8 ^ a4 ^ a[j];
        me[j] = a8 ^ a4 ^ a2;
      end
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[127 - 8*(c*4 + r) -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
        end else begin
          t[127 - 8*(c*4 + r) -: 8] = m2[r] ^ m3[(r+1)%4] ^ m1[(r+2)%4] ^ m1[(r+3)%4];
        end
      end
    end
    mix_columns = t;
  endfunction

  function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
    sub_rot = {FWD_BOX[w[23:16]] ^ rc, FWD_BOX[w[15:8]], FWD_BOX[w[7:0]], FWD_BOX[w[31:24]]};
  endfunction

  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w0 = k[127:96] ^ sub_rot(k[31:0], rc);
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    key_fwd = {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] key_bwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w3 = k[31:0] ^ k[63:32];
    w2 = k[63:32] ^ k[95:64];
    w1 = k[95:64] ^ k[127:96];
    w0 = k[127:96] ^ sub_rot(w3, rc);
    key_bwd = {w0, w1, w2, w3};
  endfunction

endpackage

// File: hdl/aes_key_cell.sv
// Key schedule cell: one key expansion step, carrying the block and its first key alongside.
`timescale 1ns / 1ps
module aes_key_cell #(
  parameter int Step = 0
) (
  input  logic         clk,
  input  logic         en,
  input  logic [127:0] blk_in,
  input  logic [127:0] key0_in,
  input  logic [127:0] rkey_in,
  input  logic         enc_in,
  output logic [127:0] blk_out,
  output logic [127:0] key0_out,
  output logic [127:0] rkey_out,
  output logic         enc_out
);
  import aes_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      blk_out  <= blk_in;
      key0_out <= key0_in;
      rkey_out <= key_fwd(rkey_in, RCON[Step]);
      enc_out  <= enc_in;
    end
  end
endmodule

// File: hdl/aes_round_cell.sv
// One cipher round cell: round transform plus next round key, registered.
`timescale 1ns / 1ps
module aes_round_cell #(
  parameter int Round = 1
) (
  input  logic                clk,
  input  logic                en,
  input  aes_pkg::cell_word_t din,
  output aes_pkg::cell_word_t dout
);
  import aes_pkg::*;

  localparam logic Last = (Round == Rounds);

  logic [127:0] key_e, key_d, t, kk;
  cell_word_t   nxt;

  always_comb begin
    key_e = key_fwd(din.rkey, RCON[Round - 1]);
    key_d = key_bwd(din.rkey, RCON[Rounds - Round]);
    if (din.encrypt) begin
      kk = key_e;
      t  = shift_rows(sub_bytes(din.state, 1'b0), 1'b0);
      if (!Last) t = mix_columns(t, 1'b0);
      t = t ^ kk;
    end else begin
      kk = key_d;
      t  = sub_bytes(shift_rows(din.state, 1'b1), 1'b1) ^ kk;
      if (!Last) t = mix_columns(t, 1'b1);
    end
    nxt.state   = t;
    nxt.rkey    = kk;
    nxt.encrypt = din.encrypt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule

// File: hdl/aes128_block_cipher.sv
// Top level: AES-128 encrypt/decrypt engine built as a chain of round cells.
`timescale 1ns / 1ps
// Fully unrolled AES-128: one word in and one word out per cycle once the chain is
// full and the output is not held. From acceptance to valid output a word passes
// through ten key schedule cells that walk the key forward to the last round key
// (needed first when decrypting), then ten round cells. The chain advances together
// and stalls on output backpressure; input ready is low only while output is held.
module aes128_block_cipher (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [263:0] s_tdata,  // key_hi, key_lo, block_hi, block_lo, encrypt, pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata   // result_hi, result_lo
);
  import aes_pkg::*;

  localparam int Depth = 2 * Rounds;

  logic [Depth-1:0] vld;
  logic             adv;
  logic [127:0]     kblk  [Rounds + 1];
  logic [127:0]     kkey0 [Rounds + 1];
  logic [127:0]     krkey [Rounds + 1];
  logic             kenc  [Rounds + 1];
  cell_word_t       chain [Rounds + 1];

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[Depth-1];

  assign kkey0[0] = {s_tdata[63:0], s_tdata[127:64]};
  assign krkey[0] = {s_tdata[63:0], s_tdata[127:64]};
  assign kblk[0]  = {s_tdata[191:128], s_tdata[255:192]};
  assign kenc[0]  = s_tdata[256];

  for (genvar g = 0; g < Rounds; g++) begin : g_key
    aes_key_cell #(.Step(g)) u_key (
      .clk     (clk),
      .en      (adv),
      .blk_in  (kblk[g]),
      .key0_in (kkey0[g]),
      .rkey_in (krkey[g]),
      .enc_in  (kenc[g]),
      .blk_out (kblk[g+1]),
      .key0_out(kkey0[g+1]),
      .rkey_out(krkey[g+1]),
      .enc_out (kenc[g+1])
    );
  end

  // first round key: key as given for encrypt, last expanded key for decrypt
  always_comb begin
    chain[0].encrypt = kenc[Rounds];
    chain[0].rkey    = kenc[Rounds] ? kkey0[Rounds] : krkey[Rounds];
    chain[0].state   = kblk[Rounds] ^ chain[0].rkey;
  end

  for (genvar g = 1; g <= Rounds; g++) begin : g_round
    aes_round_cell #(.Round(g)) u_round (
      .clk (clk),
      .en  (adv),
      .din (chain[g-1]),
      .dout(chain[g])
    );
  end

  assign m_tdata = {chain[Rounds].state[63:0], chain[Rounds].state[127:64]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], s_tvalid};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready not tied to output stall");
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted word not tracked");
endmodule
